// ===== src/apcc_pkg.sv =====
// Package for the all-pairs collision checker: item kinds, controller states,
// datapath command and status structs and sizing constants. No dependencies.
`default_nettype none
package apcc_pkg;

  localparam int unsigned MaxColliders = 8;
  localparam int unsigned CoordWidth   = 32;
  localparam int unsigned FieldWidth   = 32;
  localparam int unsigned IndexWidth   = 3;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_SPHERE = 2'd1,
    KIND_BOX    = 2'd2,
    KIND_CHECK  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_EVAL,
    ST_EMIT,
    ST_END
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add_sphere;
    logic add_box;
    logic box_sel;
    logic load_pair;
    logic eval;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== src/all_pairs_collision_checker_top.sv =====
// All-pairs collision checker top level: controller plus datapath.
// Clear and add items are taken while idle. A check walks each pair through
// operand select, square and compare, then emits the end marker,
// paced by the shared pair test unit; a pair with a hit waits while the output is stalled.
// Reset (rst_ni, async, active low) empties both tables and clears overflow.
// Depends on apcc_pkg, apcc_ctrl and apcc_datapath.
`default_nettype none
module all_pairs_collision_checker_top import apcc_pkg::*; #(
  parameter int unsigned MAX_COLLIDERS = MaxColliders,
  parameter int unsigned COORD_WIDTH   = CoordWidth
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            kind_i,
  input  wire logic [31:0]           attribute_i,
  input  wire logic [31:0]           mask_i,
  input  wire logic signed [31:0]    pos_x_i,
  input  wire logic signed [31:0]    pos_y_i,
  input  wire logic signed [31:0]    pos_z_i,
  input  wire logic signed [31:0]    lo_x_or_radius_i,
  input  wire logic signed [31:0]    lo_y_i,
  input  wire logic signed [31:0]    lo_z_i,
  input  wire logic signed [31:0]    hi_x_i,
  input  wire logic signed [31:0]    hi_y_i,
  input  wire logic signed [31:0]    hi_z_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       pair_found_o,
  output logic                       box_pair_o,
  output logic [2:0]                 first_index_o,
  output logic [2:0]                 second_index_o,
  output logic                       overflow_o,
  output logic                       last_o
);

  localparam int unsigned IdxW = (MAX_COLLIDERS > 1) ? $clog2(MAX_COLLIDERS) : 1;

  dp_cmd_t         cmd;
  dp_sts_t         sts;
  logic [IdxW-1:0] wr_idx, idx_a, idx_b;

  // Sequencing and result register.
  apcc_ctrl #(.MAX_COLLIDERS(MAX_COLLIDERS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i,
    .out_valid_o, .out_stall_i, .pair_found_o, .box_pair_o,
    .first_index_o, .second_index_o, .overflow_o, .last_o,
    .cmd_o(cmd), .wr_idx_o(wr_idx), .idx_a_o(idx_a), .idx_b_o(idx_b), .sts_i(sts)
  );

  // Tables and pair tests.
  apcc_datapath #(.MAX_COLLIDERS(MAX_COLLIDERS), .COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .wr_idx_i(wr_idx), .idx_a_i(idx_a), .idx_b_i(idx_b),
    .attribute_i, .mask_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .lo_x_i(lo_x_or_radius_i), .lo_y_i, .lo_z_i, .hi_x_i, .hi_y_i, .hi_z_i,
    .sts_o(sts)
  );

endmodule
`default_nettype wire

// ===== src/apcc_datapath.sv =====
// Datapath of the collision checker: collider tables, pair operand registers
// and the sphere and box tests. Depends on apcc_pkg.
`default_nettype none
module apcc_datapath import apcc_pkg::*; #(
  parameter int unsigned MAX_COLLIDERS = MaxColliders,
  parameter int unsigned COORD_WIDTH   = CoordWidth,
  localparam int unsigned IdxW = (MAX_COLLIDERS > 1) ? $clog2(MAX_COLLIDERS) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire dp_cmd_t                cmd_i,
  input  wire logic [IdxW-1:0]        wr_idx_i,
  input  wire logic [IdxW-1:0]        idx_a_i,
  input  wire logic [IdxW-1:0]        idx_b_i,
  input  wire logic [FieldWidth-1:0]  attribute_i,
  input  wire logic [FieldWidth-1:0]  mask_i,
  input  wire logic [31:0]            pos_x_i,
  input  wire logic [31:0]            pos_y_i,
  input  wire logic [31:0]            pos_z_i,
  input  wire logic [31:0]            lo_x_i,
  input  wire logic [31:0]            lo_y_i,
  input  wire logic [31:0]            lo_z_i,
  input  wire logic [31:0]            hi_x_i,
  input  wire logic [31:0]            hi_y_i,
  input  wire logic [31:0]            hi_z_i,
  output dp_sts_t                     sts_o
);

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned SW = CW + 1;      // sums and differences
  localparam int unsigned PW = 2 * SW;      // squares

  typedef logic signed [CW-1:0] crd_t;
  typedef crd_t [2:0] vec_t;

  // Sphere table (vector x,y,z, radius kept in lo[0]) and box table.
  logic [FieldWidth-1:0] s_attr_q [MAX_COLLIDERS];
  logic [FieldWidth-1:0] s_mask_q [MAX_COLLIDERS];
  vec_t                  s_pos_q  [MAX_COLLIDERS];
  crd_t                  s_rad_q  [MAX_COLLIDERS];
  logic [FieldWidth-1:0] b_attr_q [MAX_COLLIDERS];
  logic [FieldWidth-1:0] b_mask_q [MAX_COLLIDERS];
  vec_t                  b_pos_q  [MAX_COLLIDERS];
  vec_t                  b_lo_q   [MAX_COLLIDERS];
  vec_t                  b_hi_q   [MAX_COLLIDERS];

  vec_t in_pos, in_lo, in_hi;
  assign in_pos = {crd_t'(pos_z_i[CW-1:0]), crd_t'(pos_y_i[CW-1:0]), crd_t'(pos_x_i[CW-1:0])};
  assign in_lo  = {crd_t'(lo_z_i[CW-1:0]), crd_t'(lo_y_i[CW-1:0]), crd_t'(lo_x_i[CW-1:0])};
  assign in_hi  = {crd_t'(hi_z_i[CW-1:0]), crd_t'(hi_y_i[CW-1:0]), crd_t'(hi_x_i[CW-1:0])};

  // Table writes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_sphere) begin
      s_attr_q[wr_idx_i] <= attribute_i;
      s_mask_q[wr_idx_i] <= mask_i;
      s_pos_q[wr_idx_i]  <= in_pos;
      s_rad_q[wr_idx_i]  <= in_lo[0];
    end
    if (cmd_i.add_box) begin
      b_attr_q[wr_idx_i] <= attribute_i;
      b_mask_q[wr_idx_i] <= mask_i;
      b_pos_q[wr_idx_i]  <= in_pos;
      b_lo_q[wr_idx_i]   <= in_lo;
      b_hi_q[wr_idx_i]   <= in_hi;
    end
  end

  // First stage: filter, differences, radius sum and box bounds test for the selected pair.
  logic                  filt_q;
  logic signed [SW-1:0]  d_q [3];
  logic signed [SW-1:0]  rs_q;
  logic                  box_ok_q;

  logic                  filt_d;
  logic signed [SW-1:0]  d_d [3];
  logic                  box_ok_d;

  always_comb begin
    logic signed [SW-1:0] alo, ahi, blo, bhi;
    if (cmd_i.box_sel) begin
      filt_d = |(b_attr_q[idx_a_i] & b_mask_q[idx_b_i]) &&
               |(b_attr_q[idx_b_i] & b_mask_q[idx_a_i]);
    end else begin
      filt_d = |(s_attr_q[idx_a_i] & s_mask_q[idx_b_i]) &&
               |(s_attr_q[idx_b_i] & s_mask_q[idx_a_i]);
    end
    box_ok_d = 1'b1;
    for (int k = 0; k < 3; k++) begin
      d_d[k] = SW'(s_pos_q[idx_a_i][k]) - SW'(s_pos_q[idx_b_i][k]);
      alo = SW'(b_pos_q[idx_a_i][k]) + SW'(b_lo_q[idx_a_i][k]);
      ahi = SW'(b_pos_q[idx_a_i][k]) + SW'(b_hi_q[idx_a_i][k]);
      blo = SW'(b_pos_q[idx_b_i][k]) + SW'(b_lo_q[idx_b_i][k]);
      bhi = SW'(b_pos_q[idx_b_i][k]) + SW'(b_hi_q[idx_b_i][k]);
      if (!(alo <= bhi && ahi >= blo)) box_ok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pair) begin
      filt_q   <= filt_d;
      box_ok_q <= box_ok_d;
      rs_q     <= SW'(s_rad_q[idx_a_i]) + SW'(s_rad_q[idx_b_i]);
      for (int k = 0; k < 3; k++) d_q[k] <= d_d[k];
    end
  end

  // Second stage: squares, one multiplier per term, registered.
  logic [PW-1:0] sq_q [3];
  logic [PW-1:0] rsq_q;
  logic          rneg_q;
  logic          fbox_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      for (int k = 0; k < 3; k++) sq_q[k] <= PW'(d_q[k] * d_q[k]);
      rsq_q  <= PW'(rs_q * rs_q);
      rneg_q <= rs_q[SW-1];
      fbox_q <= filt_q && box_ok_q;
    end
  end

  // Final compare of the sum of squares.
  logic [PW+1:0] dsum;
  assign dsum = (PW+2)'(sq_q[0]) + (PW+2)'(sq_q[1]) + (PW+2)'(sq_q[2]);

  logic          sph_hit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sph_hit_q <= 1'b0;
    end else begin
      sph_hit_q <= filt_q && !rs_q[SW-1];
    end
  end

  logic box_mode_q;
  always_ff @(posedge clk_i) begin
    box_mode_q <= cmd_i.box_sel;
  end

  assign sts_o.hit = box_mode_q ? fbox_q
                                : (sph_hit_q && !rneg_q && dsum <= (PW+2)'(rsq_q));

endmodule
`default_nettype wire

// ===== src/apcc_ctrl.sv =====
// Controller of the collision checker: item intake, table counts, the pair
// walk and the result register. Depends on apcc_pkg.
`default_nettype none
module apcc_ctrl import apcc_pkg::*; #(
  parameter int unsigned MAX_COLLIDERS = MaxColliders,
  localparam int unsigned IdxW = (MAX_COLLIDERS > 1) ? $clog2(MAX_COLLIDERS) : 1,
  localparam int unsigned CntW = $clog2(MAX_COLLIDERS + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            kind_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       pair_found_o,
  output logic                       box_pair_o,
  output logic [IndexWidth-1:0]      first_index_o,
  output logic [IndexWidth-1:0]      second_index_o,
  output logic                       overflow_o,
  output logic                       last_o,
  output dp_cmd_t                    cmd_o,
  output logic [IdxW-1:0]            wr_idx_o,
  output logic [IdxW-1:0]            idx_a_o,
  output logic [IdxW-1:0]            idx_b_o,
  input  wire dp_sts_t               sts_i
);

  state_e state_q, state_d;
  logic [CntW-1:0] scnt_q, scnt_d, bcnt_q, bcnt_d;
  logic            ovf_q, ovf_d;
  logic [IdxW-1:0] ia_q, ia_d, ib_q, ib_d;
  logic            box_q, box_d;
  logic            outv_q, outv_d;
  logic            found_q, found_d, obox_q, obox_d, last_q, last_d;
  logic            oovf_q, oovf_d;
  logic [IdxW-1:0] oa_q, oa_d, ob_q, ob_d;

  logic in_acc, out_free;
  assign out_free = !outv_q || !out_stall_i;
  assign in_acc   = in_valid_i && !in_stall_o;

  // Next pair after (ia, ib) in the current table, or the next table.
  logic [CntW-1:0] cur_cnt;
  logic            pair_more;
  logic [IdxW-1:0] na, nb;
  logic            nbox, walk_done;
  always_comb begin
    cur_cnt = box_q ? bcnt_q : scnt_q;
    na = ia_q;
    nb = ib_q;
    nbox = box_q;
    walk_done = 1'b0;
    pair_more = 1'b0;
    if (CntW'(ib_q) + 1'b1 < cur_cnt) begin
      nb = ib_q + 1'b1;
      pair_more = 1'b1;
    end else if (CntW'(ia_q) + 2'd2 < cur_cnt) begin
      na = ia_q + 1'b1;
      nb = ia_q + 2'd2;
      pair_more = 1'b1;
    end
    if (!pair_more) begin
      if (!box_q && bcnt_q >= CntW'(2)) begin
        nbox = 1'b1;
        na = '0;
        nb = IdxW'(1);
      end else begin
        walk_done = 1'b1;
      end
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    scnt_d = scnt_q; bcnt_d = bcnt_q; ovf_d = ovf_q;
    ia_d = ia_q; ib_d = ib_q; box_d = box_q;
    outv_d = outv_q && out_stall_i;
    found_d = found_q; obox_d = obox_q; last_d = last_q; oa_d = oa_q; ob_d = ob_q;
    oovf_d = oovf_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (kind_e'(kind_i))
            KIND_CLEAR: begin
              scnt_d = '0;
              bcnt_d = '0;
            end
            KIND_SPHERE: begin
              if (scnt_q >= CntW'(MAX_COLLIDERS)) ovf_d = 1'b1;
              else scnt_d = scnt_q + 1'b1;
            end
            KIND_BOX: begin
              if (bcnt_q >= CntW'(MAX_COLLIDERS)) ovf_d = 1'b1;
              else bcnt_d = bcnt_q + 1'b1;
            end
            KIND_CHECK: begin
              ia_d = '0;
              ib_d = IdxW'(1);
              if (scnt_q >= CntW'(2)) begin
                box_d = 1'b0;
                state_d = ST_TEST;
              end else if (bcnt_q >= CntW'(2)) begin
                box_d = 1'b1;
                state_d = ST_TEST;
              end else begin
                state_d = ST_END;
              end
            end
            default: ;
          endcase
        end
      end
      ST_TEST: state_d = ST_EVAL;
      ST_EVAL: state_d = ST_EMIT;
      ST_EMIT: begin
        if (!sts_i.hit || out_free) begin
          if (sts_i.hit) begin
            outv_d = 1'b1; found_d = 1'b1; obox_d = box_q; last_d = 1'b0;
            oa_d = ia_q; ob_d = ib_q; oovf_d = ovf_q;
          end
          ia_d = na; ib_d = nb; box_d = nbox;
          state_d = walk_done ? ST_END : ST_TEST;
        end
      end
      ST_END: begin
        if (out_free) begin
          outv_d = 1'b1; found_d = 1'b0; obox_d = 1'b0; last_d = 1'b1;
          oa_d = '0; ob_d = '0; oovf_d = ovf_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o = '0;
    cmd_o.add_sphere = in_acc && kind_i == KIND_SPHERE && scnt_q < CntW'(MAX_COLLIDERS);
    cmd_o.add_box    = in_acc && kind_i == KIND_BOX && bcnt_q < CntW'(MAX_COLLIDERS);
    cmd_o.box_sel    = box_q;
    cmd_o.load_pair  = state_q == ST_TEST;
    cmd_o.eval       = state_q == ST_EVAL;
    wr_idx_o = (kind_i == KIND_BOX) ? bcnt_q[IdxW-1:0] : scnt_q[IdxW-1:0];
    idx_a_o  = ia_q;
    idx_b_o  = ib_q;
    in_stall_o = state_q != ST_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scnt_q <= '0; bcnt_q <= '0; ovf_q <= 1'b0;
      ia_q <= '0; ib_q <= '0; box_q <= 1'b0;
      outv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scnt_q <= scnt_d; bcnt_q <= bcnt_d; ovf_q <= ovf_d;
      ia_q <= ia_d; ib_q <= ib_d; box_q <= box_d;
      outv_q <= outv_d;
    end
  end

  // The overflow flag is captured with each result item so that a waiting
  // item keeps its payload.
  always_ff @(posedge clk_i) begin
    found_q <= found_d; obox_q <= obox_d; last_q <= last_d;
    oa_q <= oa_d; ob_q <= ob_d; oovf_q <= oovf_d;
  end

  assign out_valid_o    = outv_q;
  assign pair_found_o   = found_q;
  assign box_pair_o     = obox_q;
  assign first_index_o  = IndexWidth'(oa_q);
  assign second_index_o = IndexWidth'(ob_q);
  assign overflow_o     = oovf_q;
  assign last_o         = last_q;

endmodule
`default_nettype wire

// ===== tb/collision_scoreboard.sv =====
// Watches both channels of the all-pairs collision checker, predicts the
// pair reports of every check and compares them. Depends on apcc_pkg.
`timescale 1ns / 100ps
`default_nettype none
module collision_scoreboard import apcc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic [1:0]         kind_i,
  input  wire logic [31:0]        attribute_i,
  input  wire logic [31:0]        mask_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [31:0] lo_x_or_radius_i,
  input  wire logic signed [31:0] lo_y_i,
  input  wire logic signed [31:0] lo_z_i,
  input  wire logic signed [31:0] hi_x_i,
  input  wire logic signed [31:0] hi_y_i,
  input  wire logic signed [31:0] hi_z_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic               pair_found_i,
  input  wire logic               box_pair_i,
  input  wire logic [2:0]         first_index_i,
  input  wire logic [2:0]         second_index_i,
  input  wire logic               overflow_i,
  input  wire logic               last_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      pairs_seen_o
);

  typedef struct packed {
    logic       found;
    logic       box;
    logic [2:0] first;
    logic [2:0] second;
    logic       ovf;
    logic       last;
  } pair_report_t;

  // One collider: filter, position and either radius or low/high offsets.
  typedef struct {
    logic [31:0]        attr;
    logic [31:0]        msk;
    logic signed [31:0] pos [3];
    logic signed [31:0] lo  [3];
    logic signed [31:0] hi  [3];
  } collider_t;

  collider_t    spheres [MaxColliders];
  collider_t    boxes   [MaxColliders];
  int           n_spheres;
  int           n_boxes;
  logic         ovf_flag;
  pair_report_t reports_q [$];

  function automatic bit filters_pass(collider_t a, collider_t b);
    return ((a.attr & b.msk) != 0) && ((b.attr & a.msk) != 0);
  endfunction

  // Exact squared distance against squared radius sum, in 128 bits.
  function automatic bit spheres_touch(collider_t a, collider_t b);
    logic signed [33:0]  rsum;
    logic signed [33:0]  d;
    logic        [127:0] dist2;
    logic        [127:0] r2;
    dist2 = '0;
    rsum = 34'(a.lo[0]) + 34'(b.lo[0]);
    if (rsum < 0) return 0;
    for (int k = 0; k < 3; k++) begin
      d = 34'(a.pos[k]) - 34'(b.pos[k]);
      if (d < 0) d = -d;
      dist2 += 128'(d) * 128'(d);
    end
    r2 = 128'(rsum) * 128'(rsum);
    return dist2 <= r2;
  endfunction

  function automatic bit boxes_overlap(collider_t a, collider_t b);
    for (int k = 0; k < 3; k++) begin
      if (!((34'(a.pos[k]) + 34'(a.lo[k]) <= 34'(b.pos[k]) + 34'(b.hi[k])) &&
            (34'(a.pos[k]) + 34'(a.hi[k]) >= 34'(b.pos[k]) + 34'(b.lo[k]))))
        return 0;
    end
    return 1;
  endfunction

  // Prediction on each accepted input item.
  always @(posedge clk_i) begin
    collider_t c;
    pair_report_t r;
    if (rst_ni && in_valid_i && !in_stall_i) begin
      c.attr = attribute_i;
      c.msk  = mask_i;
      c.pos[0] = pos_x_i; c.pos[1] = pos_y_i; c.pos[2] = pos_z_i;
      c.lo[0] = lo_x_or_radius_i; c.lo[1] = lo_y_i; c.lo[2] = lo_z_i;
      c.hi[0] = hi_x_i; c.hi[1] = hi_y_i; c.hi[2] = hi_z_i;
      case (kind_e'(kind_i))
        KIND_CLEAR: begin
          n_spheres = 0;
          n_boxes = 0;
        end
        KIND_SPHERE: begin
          if (n_spheres >= MaxColliders) ovf_flag = 1;
          else begin
            spheres[n_spheres] = c;
            n_spheres++;
          end
        end
        KIND_BOX: begin
          if (n_boxes >= MaxColliders) ovf_flag = 1;
          else begin
            boxes[n_boxes] = c;
            n_boxes++;
          end
        end
        default: begin
          for (int i = 0; i < n_spheres; i++)
            for (int j = i + 1; j < n_spheres; j++)
              if (filters_pass(spheres[i], spheres[j]) &&
                  spheres_touch(spheres[i], spheres[j])) begin
                r = '{1'b1, 1'b0, 3'(i), 3'(j), ovf_flag, 1'b0};
                reports_q.insert(reports_q.size(), r);
              end
          for (int i = 0; i < n_boxes; i++)
            for (int j = i + 1; j < n_boxes; j++)
              if (filters_pass(boxes[i], boxes[j]) &&
                  boxes_overlap(boxes[i], boxes[j])) begin
                r = '{1'b1, 1'b1, 3'(i), 3'(j), ovf_flag, 1'b0};
                reports_q.insert(reports_q.size(), r);
              end
          r = '{1'b0, 1'b0, 3'd0, 3'd0, ovf_flag, 1'b1};
          reports_q.insert(reports_q.size(), r);
        end
      endcase
    end
  end

  // Comparison of each accepted result item against the oldest prediction.
  always @(posedge clk_i) begin
    pair_report_t e;
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (reports_q.size() == 0) begin
        $error("unexpected result item");
        fail_count_o++;
      end else begin
        e = reports_q.pop_front();
        if (e.found) pairs_seen_o++;
        if (pair_found_i !== e.found) begin
          $error("pair_found: expected %0d, got %0d", e.found, pair_found_i);
          fail_count_o++;
        end
        if (box_pair_i !== e.box) begin
          $error("box_pair: expected %0d, got %0d", e.box, box_pair_i);
          fail_count_o++;
        end
        if (first_index_i !== e.first) begin
          $error("first_index: expected %0d, got %0d", e.first, first_index_i);
          fail_count_o++;
        end
        if (second_index_i !== e.second) begin
          $error("second_index: expected %0d, got %0d", e.second, second_index_i);
          fail_count_o++;
        end
        if (overflow_i !== e.ovf) begin
          $error("overflow: expected %0d, got %0d", e.ovf, overflow_i);
          fail_count_o++;
        end
        if (last_i !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, last_i);
          fail_count_o++;
        end
      end
    end
  end

  always @(negedge clk_i) pending_o = reports_q.size();

  initial begin
    fail_count_o = 0;
    pairs_seen_o = 0;
    pending_o = 0;
    n_spheres = 0;
    n_boxes = 0;
    ovf_flag = 0;
  end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench top for all_pairs_collision_checker_top: stimulus, idling and
// verdict. Depends on apcc_pkg, the block and collision_scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_top import apcc_pkg::*;;

  localparam int WatchdogLimit = 20000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [1:0]         kind = KIND_CLEAR;
  logic [31:0]        attribute = '0;
  logic [31:0]        mask = '0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [31:0] lo_x = '0, lo_y = '0, lo_z = '0;
  logic signed [31:0] hi_x = '0, hi_y = '0, hi_z = '0;
  logic               out_valid;
  logic               out_stall = 1;
  logic               pair_found, box_pair, overflow, last;
  logic [2:0]         first_index, second_index;
  int                 fail_count, pending, pairs_seen;
  int                 idle_cycles = 0;
  int                 items_sent = 0;
  bit                 hold_output = 0;
  bit                 stim_done = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  all_pairs_collision_checker_top u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .attribute_i(attribute), .mask_i(mask),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .lo_x_or_radius_i(lo_x), .lo_y_i(lo_y), .lo_z_i(lo_z),
    .hi_x_i(hi_x), .hi_y_i(hi_y), .hi_z_i(hi_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pair_found_o(pair_found), .box_pair_o(box_pair),
    .first_index_o(first_index), .second_index_o(second_index),
    .overflow_o(overflow), .last_o(last)
  );

  collision_scoreboard u_scoreboard (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .kind_i(kind), .attribute_i(attribute), .mask_i(mask),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .lo_x_or_radius_i(lo_x), .lo_y_i(lo_y), .lo_z_i(lo_z),
    .hi_x_i(hi_x), .hi_y_i(hi_y), .hi_z_i(hi_z),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .pair_found_i(pair_found), .box_pair_i(box_pair),
    .first_index_i(first_index), .second_index_i(second_index),
    .overflow_i(overflow), .last_i(last),
    .fail_count_o(fail_count), .pending_o(pending), .pairs_seen_o(pairs_seen)
  );

  // Offers one item after a random gap and waits until it is accepted.
  // Valid drops only when a gap follows, so it is written once per edge.
  task automatic send_item(kind_e k, logic [31:0] at, logic [31:0] mk,
                           logic [31:0] p [3], logic [31:0] l [3],
                           logic [31:0] h [3], bit quick = 0);
    int gap;
    gap = quick ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    kind <= k;
    attribute <= at;
    mask <= mk;
    pos_x <= p[0]; pos_y <= p[1]; pos_z <= p[2];
    lo_x <= l[0]; lo_y <= l[1]; lo_z <= l[2];
    hi_x <= h[0]; hi_y <= h[1]; hi_z <= h[2];
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // A collider near the origin with small values, or one with full-range values.
  task automatic send_collider(kind_e k, bit wide);
    logic [31:0] p [3], l [3], h [3];
    logic [31:0] at, mk;
    for (int a = 0; a < 3; a++) begin
      if (wide) begin
        p[a] = $urandom(); l[a] = $urandom(); h[a] = $urandom();
      end else begin
        p[a] = $urandom_range(0, 'h60000) - 'h30000;
        l[a] = -$urandom_range(0, 'h20000);
        h[a] = $urandom_range(0, 'h20000);
      end
    end
    if (k == KIND_SPHERE && !wide) l[0] = $urandom_range(0, 'h28000);
    at = ($urandom_range(0, 4) == 0) ? $urandom() : 32'h1 << $urandom_range(0, 1);
    mk = ($urandom_range(0, 4) == 0) ? $urandom() : 32'h3;
    send_item(k, at, mk, p, l, h);
  endtask

  task automatic send_plain(kind_e k);
    logic [31:0] z [3];
    z = '{default: $urandom()};
    send_item(k, $urandom(), $urandom(), z, z, z);
  endtask

  // Receiver: random stalls per item, one long hold-off, and stall-free runs.
  always @(posedge clk) begin
    if (hold_output) out_stall <= 1;
    else if (idle_cycles > 0) begin
      out_stall <= 1;
      idle_cycles <= idle_cycles - 1;
    end else begin
      out_stall <= 0;
      if (out_valid && !out_stall)
        idle_cycles <= (items_sent % 90 < 30) ? 0 : $urandom_range(0, 9);
    end
  end

  // Watchdog on cycles with no accepted item on either side.
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || stim_done ||
        hold_output)
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchdogLimit) begin
      $display("all_pairs_collision_checker_top regression: fail");
      $finish;
    end
  end

  initial begin
    logic [31:0] p [3], l [3], h [3];
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty check, touching spheres, extremes, overlapping boxes.
    send_plain(KIND_CHECK);
    p = '{32'h0, 32'h0, 32'h0}; l = '{32'h10000, 0, 0}; h = '{0, 0, 0};
    send_item(KIND_SPHERE, 32'h1, 32'h1, p, l, h);
    p = '{32'h20000, 32'h0, 32'h0};
    send_item(KIND_SPHERE, 32'h1, 32'h1, p, l, h);
    p = '{32'h80000000, 32'h80000000, 32'h80000000}; l = '{32'h7fffffff, 0, 0};
    send_item(KIND_SPHERE, 32'hffffffff, 32'hffffffff, p, l, h);
    p = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    send_item(KIND_SPHERE, 32'hffffffff, 32'hffffffff, p, l, h);
    l = '{32'h80000000, 0, 0};
    send_item(KIND_SPHERE, 32'hffffffff, 32'h0, p, l, h);
    p = '{0, 0, 0}; l = '{32'hffff0000, 32'hffff0000, 32'hffff0000};
    h = '{32'h10000, 32'h10000, 32'h10000};
    send_item(KIND_BOX, 32'h2, 32'h2, p, l, h);
    p = '{32'h20000, 32'h20000, 32'h20000};
    send_item(KIND_BOX, 32'h2, 32'h2, p, l, h);
    l = '{32'h80000000, 32'h80000000, 32'h80000000};
    h = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    send_item(KIND_BOX, 32'h2, 32'h2, p, l, h);
    send_plain(KIND_CHECK);
    // Fill both tables past capacity to raise overflow.
    for (int n = 0; n < 7; n++) send_collider(KIND_SPHERE, 0);
    for (int n = 0; n < 6; n++) send_collider(KIND_BOX, 0);
    send_plain(KIND_CHECK);
    send_plain(KIND_CLEAR);

    // Back pressure: receiver holds off while checks keep coming.
    fork
      begin
        hold_output = 1;
        repeat (400) @(posedge clk);
        hold_output = 0;
      end
    join_none
    for (int n = 0; n < 4; n++) send_collider(KIND_SPHERE, 0);
    for (int n = 0; n < 6; n++) send_item(KIND_CHECK, 0, 0, p, l, h, 1);
    send_plain(KIND_CLEAR);

    // Random: mostly fill-then-check sequences, some noise.
    while (items_sent < 380) begin
      int ns, nb;
      ns = $urandom_range(0, 8);
      nb = $urandom_range(0, 8);
      if ($urandom_range(0, 9) == 0) send_plain(kind_e'($urandom_range(0, 3)));
      for (int n = 0; n < ns; n++) send_collider(KIND_SPHERE, $urandom_range(0, 7) == 0);
      for (int n = 0; n < nb; n++) send_collider(KIND_BOX, $urandom_range(0, 7) == 0);
      send_plain(KIND_CHECK);
      if ($urandom_range(0, 2) != 0) send_plain(KIND_CLEAR);
    end
    send_plain(KIND_CHECK);
    in_valid <= 0;

    stim_done = 1;
    // Let the count of outstanding predictions include the last check.
    @(negedge clk);
    for (int w = 0; pending != 0; w++) begin
      @(posedge clk);
      if (w > WatchdogLimit) begin
        $display("all_pairs_collision_checker_top regression: fail");
        $finish;
      end
    end
    repeat (200) @(posedge clk);
    $display("Sent %0d items; %0d colliding pairs were reported and checked.",
             items_sent, pairs_seen);
    if (fail_count == 0 && pending == 0)
      $display("all_pairs_collision_checker_top regression: pass");
    else
      $display("all_pairs_collision_checker_top regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
src/apcc_pkg.sv
src/apcc_datapath.sv
src/apcc_ctrl.sv
src/all_pairs_collision_checker_top.sv
tb/collision_scoreboard.sv
tb/tb_top.sv
